### hw/rtl/dcde_pkg.sv
package dcde_pkg;

  // Field widths fixed by the interface
  localparam int SampleWidth   = 10;
  localparam int CodeWidth     = 18;
  localparam int LengthWidth   = 5;
  localparam int CategoryWidth = 4;
  localparam int PrefixWidth   = 8;
  localparam int PrefixCount   = 11;

  // Default sample precision
  localparam int SampleBitsDefault = 10;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          block_start;
  } in_t;

  typedef struct packed {
    logic [CodeWidth-1:0]     code_word;
    logic [LengthWidth-1:0]   code_length;
    logic [CategoryWidth-1:0] category;
  } out_t;

  // Prefix code bits, indexed by category
  function automatic logic [PrefixWidth-1:0] prefix_code(input logic [CategoryWidth-1:0] cat);
    logic [PrefixWidth-1:0] code;
    case (cat)
      4'd0:    code = 8'd2;
      4'd1:    code = 8'd3;
      4'd2:    code = 8'd4;
      4'd3:    code = 8'd0;
      4'd4:    code = 8'd5;
      4'd5:    code = 8'd6;
      4'd6:    code = 8'd14;
      4'd7:    code = 8'd30;
      4'd8:    code = 8'd62;
      4'd9:    code = 8'd126;
      4'd10:   code = 8'd254;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

  // Prefix length in bits, indexed by category
  function automatic logic [LengthWidth-1:0] prefix_size(input logic [CategoryWidth-1:0] cat);
    logic [LengthWidth-1:0] size;
    case (cat)
      4'd0:    size = 5'd3;
      4'd1:    size = 5'd3;
      4'd2:    size = 5'd3;
      4'd3:    size = 5'd2;
      4'd4:    size = 5'd3;
      4'd5:    size = 5'd3;
      4'd6:    size = 5'd4;
      4'd7:    size = 5'd5;
      4'd8:    size = 5'd6;
      4'd9:    size = 5'd7;
      4'd10:   size = 5'd8;
      default: size = 5'd0;
    endcase
    return size;
  endfunction

endpackage

### hw/rtl/dcde_encode.sv
module dcde_encode #(
  parameter int SAMPLE_BITS = dcde_pkg::SampleBitsDefault
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] pred,
  output dcde_pkg::out_t                result
);

  logic signed [SAMPLE_BITS:0]            diff;
  logic                                   neg;
  logic [SAMPLE_BITS:0]                   mag_full;
  logic [SAMPLE_BITS-1:0]                 mag;
  logic [dcde_pkg::CategoryWidth-1:0]     cat;
  logic [SAMPLE_BITS-1:0]                 cat_mask;
  logic [SAMPLE_BITS-1:0]                 value_bits;
  logic [dcde_pkg::CodeWidth-1:0]         prefix_word;

  // Difference with one guard bit; magnitude fits in SAMPLE_BITS
  assign diff     = {sample[SAMPLE_BITS-1], sample} - {pred[SAMPLE_BITS-1], pred};
  assign neg      = diff[SAMPLE_BITS];
  assign mag_full = neg ? (~diff + 1'b1) : diff;
  assign mag      = mag_full[SAMPLE_BITS-1:0];

  // Category: position of the highest set magnitude bit, plus one
  always_comb begin
    cat = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (mag[i]) begin
        cat = dcde_pkg::CategoryWidth'(i + 1);
      end
    end
  end

  // Low category bits of the magnitude, inverted for a negative difference
  always_comb begin
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      cat_mask[i] = (i < int'(cat));
    end
  end

  assign value_bits = (neg ? ~mag : mag) & cat_mask;

  // Prefix above value bits
  assign prefix_word = dcde_pkg::CodeWidth'(dcde_pkg::prefix_code(cat)) << cat;

  assign result.code_word   = prefix_word | dcde_pkg::CodeWidth'(value_bits);
  assign result.code_length = dcde_pkg::prefix_size(cat)
                              + dcde_pkg::LengthWidth'(cat);
  assign result.category    = cat;

endmodule

### hw/rtl/dc_difference_category_encoder.sv
// Registered path: an accepted sample goes through the input register, then the result register.
// Throughput: one sample per cycle while out_ready is high; stage 1 fills even if stage 2 stalls.
// Reset (rst, synchronous, active high): both stages empty, predictor cleared to zero.
// The predictor follows every accepted sample; block_start forces a zero predictor.
module dc_difference_category_encoder #(
  parameter int SAMPLE_BITS = dcde_pkg::SampleBitsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dcde_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dcde_pkg::out_t out_data
);

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [SAMPLE_BITS-1:0] s1_pred;
  logic signed [SAMPLE_BITS-1:0] previous_sample;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          s2_advance;
  logic                          in_transfer;
  dcde_pkg::out_t                result;

  // Pipeline control
  assign s2_advance  = !out_valid || out_ready;
  assign in_ready    = !s1_valid || s2_advance;
  assign in_transfer = in_valid && in_ready;
  assign in_sample   = in_data.sample[SAMPLE_BITS-1:0];

  // Input stage and predictor
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      previous_sample <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (in_transfer) begin
        previous_sample <= in_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      s1_sample <= in_sample;
      s1_pred   <= in_data.block_start ? '0 : previous_sample;
    end
  end

  dcde_encode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_encode (
    .sample(s1_sample),
    .pred  (s1_pred),
    .result(result)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance && s1_valid) begin
      out_data <= result;
    end
  end

endmodule
